FILE: rtl/u8g_pkg.sv
// Shared types and constants for the UTF-8 to glyph decoder.
// No dependencies; imported by every module of the block.
`default_nettype none

package u8g_pkg;

    // Lead byte classes
    localparam logic [7:0] LEAD2_MASK = 8'hE0;
    localparam logic [7:0] LEAD2_CODE = 8'hC0;
    localparam logic [7:0] LEAD3_MASK = 8'hF0;
    localparam logic [7:0] LEAD3_CODE = 8'hE0;
    localparam logic [7:0] LEAD4_MASK = 8'hF8;
    localparam logic [7:0] LEAD4_CODE = 8'hF0;
    localparam logic [7:0] CONT_MASK  = 8'hC0;
    localparam logic [7:0] CONT_CODE  = 8'h80;

    // Smallest legal code point for each continuation count
    localparam logic [20:0] MIN_LEN1 = 21'h000080;
    localparam logic [20:0] MIN_LEN2 = 21'h000800;
    localparam logic [20:0] MIN_LEN3 = 21'h010000;

    // Glyph constants
    localparam logic [6:0] GLYPH_NEWLINE = 7'd10;
    localparam logic [6:0] GLYPH_QMARK   = 7'd63;
    localparam logic [6:0] GLYPH_FIRST   = 7'd32;
    localparam logic [6:0] GLYPH_LAST    = 7'd126;

    // Accent mark codes
    localparam logic [2:0] MARK_NONE       = 3'd0;
    localparam logic [2:0] MARK_GRAVE      = 3'd1;
    localparam logic [2:0] MARK_ACUTE      = 3'd2;
    localparam logic [2:0] MARK_CIRCUMFLEX = 3'd3;
    localparam logic [2:0] MARK_TILDE      = 3'd4;
    localparam logic [2:0] MARK_DIAERESIS  = 3'd5;
    localparam logic [2:0] MARK_CEDILLA    = 3'd6;

    // Completed code point or error waiting for the glyph lookup
    typedef struct packed {
        logic        valid;
        logic        err;
        logic [20:0] cp;
    } stage_t;

    // One result transaction
    typedef struct packed {
        logic [6:0]  glyph_char;
        logic [2:0]  accent_mark;
        logic [20:0] code_point;
        logic        substituted;
        logic        decode_error;
        logic        run_last;
    } result_t;

    // Output queue occupancy as seen by the stage control
    typedef struct packed {
        logic room_one;
        logic room_two;
    } queue_status_t;

endpackage

`default_nettype wire

FILE: rtl/u8g_assembler.sv
// Byte assembler: tracks the multi-byte sequence and registers each completed
// code point or decode error. Depends on u8g_pkg.
`default_nettype none

module u8g_assembler
    import u8g_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [7:0] text_byte,
    input  wire logic       final_byte,
    input  wire logic       stage_take,
    output stage_t          stage
);

    logic [1:0]  pending_reg, pending_next;
    logic [1:0]  seq_len_reg, seq_len_next;
    logic [20:0] partial_reg, partial_next;
    logic        s_valid_reg, s_valid_next;
    logic        s_err_reg, s_err_next;
    logic [20:0] s_cp_reg, s_cp_next;

    logic        accept;
    logic        produce;
    logic        prod_err;
    logic [20:0] prod_cp;
    logic [20:0] merged;
    logic [20:0] min_cp;

    assign in_ready = !s_valid_reg || stage_take;
    assign accept   = in_valid && in_ready;
    assign merged   = {partial_reg[14:0], text_byte[5:0]};

    // Pick the overlong threshold for the current sequence
    always_comb
    begin
        unique case (seq_len_reg)
            2'd1:    min_cp = MIN_LEN1;
            2'd2:    min_cp = MIN_LEN2;
            2'd3:    min_cp = MIN_LEN3;
            default: min_cp = '0;
        endcase
    end

    // Decode one byte against the sequence state
    always_comb
    begin
        pending_next = pending_reg;
        seq_len_next = seq_len_reg;
        partial_next = partial_reg;
        produce      = 1'b0;
        prod_err     = 1'b0;
        prod_cp      = '0;
        if (pending_reg == 2'd0)
        begin
            if (!text_byte[7])
            begin
                produce = 1'b1;
                prod_cp = {13'd0, text_byte};
            end
            else if ((text_byte & LEAD2_MASK) == LEAD2_CODE ||
                     (text_byte & LEAD3_MASK) == LEAD3_CODE ||
                     (text_byte & LEAD4_MASK) == LEAD4_CODE)
            begin
                if (final_byte)
                begin
                    produce  = 1'b1;
                    prod_err = 1'b1;
                end
                else if ((text_byte & LEAD2_MASK) == LEAD2_CODE)
                begin
                    pending_next = 2'd1;
                    seq_len_next = 2'd1;
                    partial_next = {16'd0, text_byte[4:0]};
                end
                else if ((text_byte & LEAD3_MASK) == LEAD3_CODE)
                begin
                    pending_next = 2'd2;
                    seq_len_next = 2'd2;
                    partial_next = {17'd0, text_byte[3:0]};
                end
                else
                begin
                    pending_next = 2'd3;
                    seq_len_next = 2'd3;
                    partial_next = {18'd0, text_byte[2:0]};
                end
            end
            else
            begin
                produce  = 1'b1;
                prod_err = 1'b1;
            end
        end
        else if ((text_byte & CONT_MASK) != CONT_CODE)
        begin
            // Bad continuation: drop the sequence
            produce      = 1'b1;
            prod_err     = 1'b1;
            pending_next = 2'd0;
            seq_len_next = 2'd0;
            partial_next = '0;
        end
        else if (pending_reg == 2'd1)
        begin
            produce      = 1'b1;
            prod_err     = merged < min_cp;
            prod_cp      = prod_err ? 21'd0 : merged;
            pending_next = 2'd0;
            seq_len_next = 2'd0;
            partial_next = '0;
        end
        else if (final_byte)
        begin
            // Truncated sequence
            produce      = 1'b1;
            prod_err     = 1'b1;
            pending_next = 2'd0;
            seq_len_next = 2'd0;
            partial_next = '0;
        end
        else
        begin
            pending_next = pending_reg - 2'd1;
            partial_next = merged;
        end
    end

    // Load or drain the stage register
    always_comb
    begin
        s_valid_next = s_valid_reg;
        s_err_next   = s_err_reg;
        s_cp_next    = s_cp_reg;
        if (accept)
        begin
            s_valid_next = produce;
            s_err_next   = prod_err;
            s_cp_next    = prod_cp;
        end
        else if (stage_take)
        begin
            s_valid_next = 1'b0;
        end
    end

    // Hold sequence state and stage control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= 2'd0;
            seq_len_reg <= 2'd0;
            partial_reg <= '0;
            s_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                pending_reg <= pending_next;
                seq_len_reg <= seq_len_next;
                partial_reg <= partial_next;
            end
            s_valid_reg <= s_valid_next;
        end
    end

    // Stage payload
    always_ff @(posedge clk)
    begin
        s_err_reg <= s_err_next;
        s_cp_reg  <= s_cp_next;
    end

    assign stage.valid = s_valid_reg;
    assign stage.err   = s_err_reg;
    assign stage.cp    = s_cp_reg;

endmodule

`default_nettype wire

FILE: rtl/u8g_mapper.sv
// Glyph mapper: turns a registered code point into one or two result
// transactions for the printable-ASCII font. Depends on u8g_pkg.
`default_nettype none

module u8g_mapper
    import u8g_pkg::*;
(
    input  wire stage_t stage,
    output logic        two,
    output result_t     res0,
    output result_t     res1
);

    logic [20:0] cp;
    logic [6:0]  ch;
    logic [6:0]  ch2;
    logic [2:0]  mk;
    logic        known;
    logic        pair;

    assign cp = stage.cp;

    // Look up the code point
    always_comb
    begin
        ch    = GLYPH_QMARK;
        ch2   = GLYPH_QMARK;
        mk    = MARK_NONE;
        known = 1'b1;
        pair  = 1'b0;
        if (cp == 21'd10)
        begin
            ch = GLYPH_NEWLINE;
        end
        else if (cp >= {14'd0, GLYPH_FIRST} && cp <= {14'd0, GLYPH_LAST})
        begin
            ch = cp[6:0];
        end
        else
        begin
            unique case (cp)
                21'h0000C0: begin ch = 7'("A"); mk = MARK_GRAVE;      end
                21'h0000C1: begin ch = 7'("A"); mk = MARK_ACUTE;      end
                21'h0000C2: begin ch = 7'("A"); mk = MARK_CIRCUMFLEX; end
                21'h0000C3: begin ch = 7'("A"); mk = MARK_TILDE;      end
                21'h0000C4: begin ch = 7'("A"); mk = MARK_DIAERESIS;  end
                21'h0000C7: begin ch = 7'("C"); mk = MARK_CEDILLA;    end
                21'h0000C8: begin ch = 7'("E"); mk = MARK_GRAVE;      end
                21'h0000C9: begin ch = 7'("E"); mk = MARK_ACUTE;      end
                21'h0000CA: begin ch = 7'("E"); mk = MARK_CIRCUMFLEX; end
                21'h0000CB: begin ch = 7'("E"); mk = MARK_DIAERESIS;  end
                21'h0000CC: begin ch = 7'("I"); mk = MARK_GRAVE;      end
                21'h0000CD: begin ch = 7'("I"); mk = MARK_ACUTE;      end
                21'h0000CE: begin ch = 7'("I"); mk = MARK_CIRCUMFLEX; end
                21'h0000CF: begin ch = 7'("I"); mk = MARK_DIAERESIS;  end
                21'h0000D1: begin ch = 7'("N"); mk = MARK_TILDE;      end
                21'h0000D2: begin ch = 7'("O"); mk = MARK_GRAVE;      end
                21'h0000D3: begin ch = 7'("O"); mk = MARK_ACUTE;      end
                21'h0000D4: begin ch = 7'("O"); mk = MARK_CIRCUMFLEX; end
                21'h0000D5: begin ch = 7'("O"); mk = MARK_TILDE;      end
                21'h0000D6: begin ch = 7'("O"); mk = MARK_DIAERESIS;  end
                21'h0000D9: begin ch = 7'("U"); mk = MARK_GRAVE;      end
                21'h0000DA: begin ch = 7'("U"); mk = MARK_ACUTE;      end
                21'h0000DB: begin ch = 7'("U"); mk = MARK_CIRCUMFLEX; end
                21'h0000DC: begin ch = 7'("U"); mk = MARK_DIAERESIS;  end
                21'h0000DD: begin ch = 7'("Y"); mk = MARK_ACUTE;      end
                21'h0000E0: begin ch = 7'("a"); mk = MARK_GRAVE;      end
                21'h0000E1: begin ch = 7'("a"); mk = MARK_ACUTE;      end
                21'h0000E2: begin ch = 7'("a"); mk = MARK_CIRCUMFLEX; end
                21'h0000E3: begin ch = 7'("a"); mk = MARK_TILDE;      end
                21'h0000E4: begin ch = 7'("a"); mk = MARK_DIAERESIS;  end
                21'h0000E7: begin ch = 7'("c"); mk = MARK_CEDILLA;    end
                21'h0000E8: begin ch = 7'("e"); mk = MARK_GRAVE;      end
                21'h0000E9: begin ch = 7'("e"); mk = MARK_ACUTE;      end
                21'h0000EA: begin ch = 7'("e"); mk = MARK_CIRCUMFLEX; end
                21'h0000EB: begin ch = 7'("e"); mk = MARK_DIAERESIS;  end
                21'h0000EC: begin ch = 7'("i"); mk = MARK_GRAVE;      end
                21'h0000ED: begin ch = 7'("i"); mk = MARK_ACUTE;      end
                21'h0000EE: begin ch = 7'("i"); mk = MARK_CIRCUMFLEX; end
                21'h0000EF: begin ch = 7'("i"); mk = MARK_DIAERESIS;  end
                21'h0000F1: begin ch = 7'("n"); mk = MARK_TILDE;      end
                21'h0000F2: begin ch = 7'("o"); mk = MARK_GRAVE;      end
                21'h0000F3: begin ch = 7'("o"); mk = MARK_ACUTE;      end
                21'h0000F4: begin ch = 7'("o"); mk = MARK_CIRCUMFLEX; end
                21'h0000F5: begin ch = 7'("o"); mk = MARK_TILDE;      end
                21'h0000F6: begin ch = 7'("o"); mk = MARK_DIAERESIS;  end
                21'h0000F9: begin ch = 7'("u"); mk = MARK_GRAVE;      end
                21'h0000FA: begin ch = 7'("u"); mk = MARK_ACUTE;      end
                21'h0000FB: begin ch = 7'("u"); mk = MARK_CIRCUMFLEX; end
                21'h0000FC: begin ch = 7'("u"); mk = MARK_DIAERESIS;  end
                21'h0000FD: begin ch = 7'("y"); mk = MARK_ACUTE;      end
                21'h0000FF: begin ch = 7'("y"); mk = MARK_DIAERESIS;  end
                // Ligatures
                21'h0000C6: begin ch = 7'("A"); ch2 = 7'("e"); pair = 1'b1; end
                21'h0000DF: begin ch = 7'("s"); ch2 = 7'("s"); pair = 1'b1; end
                21'h0000E6: begin ch = 7'("a"); ch2 = 7'("e"); pair = 1'b1; end
                21'h000152: begin ch = 7'("O"); ch2 = 7'("e"); pair = 1'b1; end
                21'h000153: begin ch = 7'("o"); ch2 = 7'("e"); pair = 1'b1; end
                // Plain substitutes
                21'h0000A1: ch = 7'("!");
                21'h0000BF: ch = 7'("?");
                21'h002018: ch = 7'("'");
                21'h002019: ch = 7'("'");
                21'h00201C: ch = 7'("\"");
                21'h00201D: ch = 7'("\"");
                21'h002013: ch = 7'("-");
                21'h002014: ch = 7'("-");
                21'h002026: ch = 7'(".");
                21'h0000A0: ch = 7'(" ");
                default:    known = 1'b0;
            endcase
        end
    end

    // Build the result transactions; an error clears every field but decode_error and run_last
    always_comb
    begin
        two  = 1'b0;
        res0 = '0;
        res1 = '0;
        if (stage.err)
        begin
            res0.decode_error = 1'b1;
            res0.run_last     = 1'b1;
        end
        else
        begin
            two               = pair;
            res0.glyph_char   = ch;
            res0.accent_mark  = mk;
            res0.code_point   = cp;
            res0.substituted  = !known;
            res0.run_last     = !pair;
            res1.glyph_char   = ch2;
            res1.code_point   = cp;
            res1.run_last     = 1'b1;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/u8g_out_queue.sv
// Two-entry result queue that parts the lookup from the receiver and takes a
// ligature pair in one push. Depends on u8g_pkg.
`default_nettype none

module u8g_out_queue
    import u8g_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    push,
    input  wire logic    push_two,
    input  wire result_t push_res0,
    input  wire result_t push_res1,
    output queue_status_t status,
    output logic         out_valid,
    input  wire logic    out_ready,
    output result_t      head
);

    logic [1:0] count_reg, count_next;
    result_t    ent0_reg, ent0_next;
    result_t    ent1_reg, ent1_next;
    logic       pop;
    logic [1:0] after_pop;

    assign out_valid = count_reg != 2'd0;
    assign head      = ent0_reg;
    assign pop       = out_valid && out_ready;
    assign after_pop = pop ? count_reg - 2'd1 : count_reg;

    assign status.room_one = after_pop != 2'd2;
    assign status.room_two = after_pop == 2'd0;

    // Shift out the head, then append the new transactions
    always_comb
    begin
        ent0_next  = pop ? ent1_reg : ent0_reg;
        ent1_next  = ent1_reg;
        count_next = after_pop;
        if (push)
        begin
            unique case (after_pop)
                2'd0:
                begin
                    ent0_next  = push_res0;
                    ent1_next  = push_res1;
                    count_next = push_two ? 2'd2 : 2'd1;
                end
                2'd1:
                begin
                    ent1_next  = push_res0;
                    count_next = 2'd2;
                end
                default:
                begin
                    count_next = after_pop;
                end
            endcase
        end
    end

    // Hold occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    // Queue payload
    always_ff @(posedge clk)
    begin
        ent0_reg <= ent0_next;
        ent1_reg <= ent1_next;
    end

endmodule

`default_nettype wire

FILE: rtl/utf8_to_glyph_decoder.sv
// UTF-8 to glyph decoder top level.
// Input channel: text_byte and final_byte, taken on in_valid && in_ready.
// Output channel: one glyph transaction per out_valid && out_ready, carrying
// glyph_char, accent_mark, code_point, substituted, decode_error, run_last.
// A ligature yields two transactions with the same code point; run_last marks
// the last transaction caused by one input byte. Lead and middle bytes of a
// sequence yield nothing unless they end in an error.
// A completed result passes through the stage register, then the output
// queue, before it is offered to the receiver.
// Throughput: one byte per cycle while single-glyph results flow and the
// receiver is ready; a ligature yields two transactions through the output
// port, one per cycle, so the stage waits until both queue entries are free.
// Stall: the two-entry output queue keeps accepting while one result waits;
// once it is full the stage register holds and in_ready drops.
// Reset: asynchronous, active low; the sequence state returns to idle and the
// stage and queue are emptied. No clearing pass is needed.
// Depends on u8g_pkg, u8g_assembler, u8g_mapper, u8g_out_queue.
`default_nettype none

module utf8_to_glyph_decoder
    import u8g_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  text_byte,
    input  wire logic        final_byte,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [6:0]       glyph_char,
    output logic [2:0]       accent_mark,
    output logic [20:0]      code_point,
    output logic             substituted,
    output logic             decode_error,
    output logic             run_last
);

    stage_t        stage;
    logic          stage_take;
    logic          two;
    result_t       res0;
    result_t       res1;
    result_t       head;
    queue_status_t q_status;

    u8g_assembler u_assembler (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .text_byte  (text_byte),
        .final_byte (final_byte),
        .stage_take (stage_take),
        .stage      (stage)
    );

    u8g_mapper u_mapper (
        .stage (stage),
        .two   (two),
        .res0  (res0),
        .res1  (res1)
    );

    // Advance the stage once the queue has room for all its transactions
    assign stage_take = stage.valid && (two ? q_status.room_two : q_status.room_one);

    u8g_out_queue u_out_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (stage_take),
        .push_two  (two),
        .push_res0 (res0),
        .push_res1 (res1),
        .status    (q_status),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .head      (head)
    );

    assign glyph_char   = head.glyph_char;
    assign accent_mark  = head.accent_mark;
    assign code_point   = head.code_point;
    assign substituted  = head.substituted;
    assign decode_error = head.decode_error;
    assign run_last     = head.run_last;

endmodule

`default_nettype wire

FILE: tb/sv/glyph_stream_checker.sv
// Glyph stream checker for the UTF-8 to glyph decoder.
// Watches both channels, predicts the glyph transactions and compares them in order.
// Depends on u8g_pkg for the result layout, the byte classes and the mark codes.
`timescale 1ns / 1ps

module glyph_stream_checker
    import u8g_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    input  wire logic        in_ready,
    input  wire logic [7:0]  text_byte,
    input  wire logic        final_byte,
    input  wire logic        out_valid,
    input  wire logic        out_ready,
    input  wire logic [6:0]  glyph_char,
    input  wire logic [2:0]  accent_mark,
    input  wire logic [20:0] code_point,
    input  wire logic        substituted,
    input  wire logic        decode_error,
    input  wire logic        run_last,
    output int unsigned      mismatches,
    output int unsigned      glyphs_owed
);

    // Sequence state of the predictor
    logic [1:0]  conts_left;
    logic [1:0]  conts_total;
    logic [20:0] cp_acc;

    // Glyph transactions still to come, oldest first
    result_t glyphs_due[$];

    task automatic report_mismatch(input string what, input logic [31:0] seen,
                                   input logic [31:0] wanted);
        mismatches++;
        $display("%0t ns: %s: got 0x%0h, expected 0x%0h", $time, what, seen, wanted);
    endtask

    task automatic push_glyph(input logic [7:0] ch, input logic [2:0] mark,
                              input logic [20:0] cp, input logic sub,
                              input logic err, input logic last);
        result_t g;
        g.glyph_char   = ch[6:0];
        g.accent_mark  = mark;
        g.code_point   = cp;
        g.substituted  = sub;
        g.decode_error = err;
        g.run_last     = last;
        glyphs_due.push_back(g);
    endtask

    task automatic drop_sequence_with_error();
        conts_left  = 2'd0;
        conts_total = 2'd0;
        cp_acc      = 21'd0;
        push_glyph(8'd0, MARK_NONE, 21'd0, 1'b0, 1'b1, 1'b1);
    endtask

    // Map one completed code point to its glyphs
    task automatic map_code_point(input logic [20:0] cp);
        logic [7:0] letter;
        logic [2:0] mark;
        letter = 8'd0;
        mark   = MARK_NONE;
        // Latin-1 letters: the lower-case row repeats the upper-case one
        if (cp >= 21'h0000C0 && cp <= 21'h0000FF) begin
            case (cp[4:0])
                5'h00: begin letter = "A"; mark = MARK_GRAVE;      end
                5'h01: begin letter = "A"; mark = MARK_ACUTE;      end
                5'h02: begin letter = "A"; mark = MARK_CIRCUMFLEX; end
                5'h03: begin letter = "A"; mark = MARK_TILDE;      end
                5'h04: begin letter = "A"; mark = MARK_DIAERESIS;  end
                5'h07: begin letter = "C"; mark = MARK_CEDILLA;    end
                5'h08: begin letter = "E"; mark = MARK_GRAVE;      end
                5'h09: begin letter = "E"; mark = MARK_ACUTE;      end
                5'h0A: begin letter = "E"; mark = MARK_CIRCUMFLEX; end
                5'h0B: begin letter = "E"; mark = MARK_DIAERESIS;  end
                5'h0C: begin letter = "I"; mark = MARK_GRAVE;      end
                5'h0D: begin letter = "I"; mark = MARK_ACUTE;      end
                5'h0E: begin letter = "I"; mark = MARK_CIRCUMFLEX; end
                5'h0F: begin letter = "I"; mark = MARK_DIAERESIS;  end
                5'h11: begin letter = "N"; mark = MARK_TILDE;      end
                5'h12: begin letter = "O"; mark = MARK_GRAVE;      end
                5'h13: begin letter = "O"; mark = MARK_ACUTE;      end
                5'h14: begin letter = "O"; mark = MARK_CIRCUMFLEX; end
                5'h15: begin letter = "O"; mark = MARK_TILDE;      end
                5'h16: begin letter = "O"; mark = MARK_DIAERESIS;  end
                5'h19: begin letter = "U"; mark = MARK_GRAVE;      end
                5'h1A: begin letter = "U"; mark = MARK_ACUTE;      end
                5'h1B: begin letter = "U"; mark = MARK_CIRCUMFLEX; end
                5'h1C: begin letter = "U"; mark = MARK_DIAERESIS;  end
                5'h1D: begin letter = "Y"; mark = MARK_ACUTE;      end
                // only the lower-case y carries a diaeresis; the upper slot is sharp s
                5'h1F:
                begin
                    if (cp[5])
                    begin
                        letter = "Y";
                        mark   = MARK_DIAERESIS;
                    end
                end
                default: ;
            endcase
            if (cp[5])
                letter = letter | 8'h20;
        end

        if (cp == 21'd10)
            push_glyph({1'b0, GLYPH_NEWLINE}, MARK_NONE, cp, 1'b0, 1'b0, 1'b1);
        else if (cp >= 21'd32 && cp <= 21'd126)
            push_glyph({1'b0, cp[6:0]}, MARK_NONE, cp, 1'b0, 1'b0, 1'b1);
        else if (mark != MARK_NONE)
            push_glyph(letter, mark, cp, 1'b0, 1'b0, 1'b1);
        else
        begin
            case (cp)
                // ligatures: two transactions, the run ends on the second
                21'h0000C6:
                begin
                    push_glyph("A", MARK_NONE, cp, 1'b0, 1'b0, 1'b0);
                    push_glyph("e", MARK_NONE, cp, 1'b0, 1'b0, 1'b1);
                end
                21'h0000DF:
                begin
                    push_glyph("s", MARK_NONE, cp, 1'b0, 1'b0, 1'b0);
                    push_glyph("s", MARK_NONE, cp, 1'b0, 1'b0, 1'b1);
                end
                21'h0000E6:
                begin
                    push_glyph("a", MARK_NONE, cp, 1'b0, 1'b0, 1'b0);
                    push_glyph("e", MARK_NONE, cp, 1'b0, 1'b0, 1'b1);
                end
                21'h000152:
                begin
                    push_glyph("O", MARK_NONE, cp, 1'b0, 1'b0, 1'b0);
                    push_glyph("e", MARK_NONE, cp, 1'b0, 1'b0, 1'b1);
                end
                21'h000153:
                begin
                    push_glyph("o", MARK_NONE, cp, 1'b0, 1'b0, 1'b0);
                    push_glyph("e", MARK_NONE, cp, 1'b0, 1'b0, 1'b1);
                end
                // punctuation and space stand-ins
                21'h0000A0: push_glyph(" ", MARK_NONE, cp, 1'b0, 1'b0, 1'b1);
                21'h0000A1: push_glyph("!", MARK_NONE, cp, 1'b0, 1'b0, 1'b1);
                21'h0000BF: push_glyph("?", MARK_NONE, cp, 1'b0, 1'b0, 1'b1);
                21'h002013,
                21'h002014: push_glyph("-", MARK_NONE, cp, 1'b0, 1'b0, 1'b1);
                21'h002018,
                21'h002019: push_glyph("'", MARK_NONE, cp, 1'b0, 1'b0, 1'b1);
                21'h00201C,
                21'h00201D: push_glyph("\"", MARK_NONE, cp, 1'b0, 1'b0, 1'b1);
                21'h002026: push_glyph(".", MARK_NONE, cp, 1'b0, 1'b0, 1'b1);
                default:
                    push_glyph({1'b0, GLYPH_QMARK}, MARK_NONE, cp, 1'b1, 1'b0, 1'b1);
            endcase
        end
    endtask

    // Advance the sequence state by one accepted byte
    task automatic decode_text_byte(input logic [7:0] b, input logic fin);
        logic [1:0]  extra;
        logic [20:0] lead_bits;
        logic        lead_ok;
        logic [20:0] cp;
        logic [20:0] floor_cp;
        lead_ok   = 1'b1;
        extra     = 2'd0;
        lead_bits = 21'd0;
        if (conts_left == 2'd0)
        begin
            if (!b[7])
                map_code_point({13'd0, b});
            else
            begin
                if ((b & LEAD2_MASK) == LEAD2_CODE)
                begin
                    extra     = 2'd1;
                    lead_bits = {16'd0, b[4:0]};
                end
                else if ((b & LEAD3_MASK) == LEAD3_CODE)
                begin
                    extra     = 2'd2;
                    lead_bits = {17'd0, b[3:0]};
                end
                else if ((b & LEAD4_MASK) == LEAD4_CODE)
                begin
                    extra     = 2'd3;
                    lead_bits = {18'd0, b[2:0]};
                end
                else
                    lead_ok = 1'b0;
                // a stray continuation, a bad lead or a lead at the end of text
                if (!lead_ok || fin)
                    drop_sequence_with_error();
                else
                begin
                    conts_left  = extra;
                    conts_total = extra;
                    cp_acc      = lead_bits;
                end
            end
        end
        else if ((b & CONT_MASK) != CONT_CODE)
            drop_sequence_with_error();
        else
        begin
            cp_acc     = {cp_acc[14:0], b[5:0]};
            conts_left = conts_left - 2'd1;
            if (conts_left == 2'd0)
            begin
                cp = cp_acc;
                case (conts_total)
                    2'd1:    floor_cp = MIN_LEN1;
                    2'd2:    floor_cp = MIN_LEN2;
                    default: floor_cp = MIN_LEN3;
                endcase
                conts_total = 2'd0;
                cp_acc      = 21'd0;
                // reject overlong forms
                if (cp < floor_cp)
                    drop_sequence_with_error();
                else
                    map_code_point(cp);
            end
            else if (fin)
                drop_sequence_with_error();
        end
    endtask

    // Compare one glyph transaction with the oldest prediction
    task automatic check_glyph();
        result_t want;
        if (glyphs_due.size() == 0)
            report_mismatch("glyph with nothing expected, code_point", code_point, 0);
        else
        begin
            want = glyphs_due.pop_front();
            if (glyph_char !== want.glyph_char)
                report_mismatch("glyph_char", glyph_char, want.glyph_char);
            if (accent_mark !== want.accent_mark)
                report_mismatch("accent_mark", accent_mark, want.accent_mark);
            if (code_point !== want.code_point)
                report_mismatch("code_point", code_point, want.code_point);
            if (substituted !== want.substituted)
                report_mismatch("substituted", substituted, want.substituted);
            if (decode_error !== want.decode_error)
                report_mismatch("decode_error", decode_error, want.decode_error);
            if (run_last !== want.run_last)
                report_mismatch("run_last", run_last, want.run_last);
        end
    endtask

    // Sample both channels at the rising edge
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            conts_left  = 2'd0;
            conts_total = 2'd0;
            cp_acc      = 21'd0;
            glyphs_due.delete();
            glyphs_owed = 0;
            mismatches  = 0;
        end
        else
        begin
            if (out_valid && out_ready)
                check_glyph();
            if (in_valid && in_ready)
                decode_text_byte(text_byte, final_byte);
            glyphs_owed = glyphs_due.size();
        end
    end

endmodule

FILE: tb/sv/utf8_to_glyph_decoder_tb.sv
// Top of the UTF-8 to glyph decoder testbench: clock, reset, byte stimulus and verdict.
// Depends on utf8_to_glyph_decoder, u8g_pkg and glyph_stream_checker.
`timescale 1ns / 1ps

module utf8_to_glyph_decoder_tb;

    logic        clk        = 1'b0;
    logic        rst_n      = 1'b0;
    logic        in_valid   = 1'b0;
    logic [7:0]  text_byte  = 8'd0;
    logic        final_byte = 1'b0;
    logic        out_ready  = 1'b0;
    logic        in_ready;
    logic        out_valid;
    logic [6:0]  glyph_char;
    logic [2:0]  accent_mark;
    logic [20:0] code_point;
    logic        substituted;
    logic        decode_error;
    logic        run_last;

    int unsigned mismatches;
    int unsigned glyphs_owed;
    int unsigned bytes_sent    = 0;
    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;

    utf8_to_glyph_decoder dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .text_byte    (text_byte),
        .final_byte   (final_byte),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .glyph_char   (glyph_char),
        .accent_mark  (accent_mark),
        .code_point   (code_point),
        .substituted  (substituted),
        .decode_error (decode_error),
        .run_last     (run_last)
    );

    glyph_stream_checker checker_i (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .text_byte    (text_byte),
        .final_byte   (final_byte),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .glyph_char   (glyph_char),
        .accent_mark  (accent_mark),
        .code_point   (code_point),
        .substituted  (substituted),
        .decode_error (decode_error),
        .run_last     (run_last),
        .mismatches   (mismatches),
        .glyphs_owed  (glyphs_owed)
    );

    // 4 ns clock
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Stall the glyph channel at random
    always @(negedge clk)
        out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);

    // Offer one byte, idling first at random, and hold it until the transaction
    task automatic put_byte(input logic [7:0] b, input logic fin);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid   <= 1'b1;
        text_byte  <= b;
        final_byte <= fin;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        bytes_sent++;
        @(negedge clk);
    endtask

    // Hold the byte channel until every predicted glyph has arrived
    task automatic wait_for_glyphs();
        in_valid <= 1'b0;
        while (glyphs_owed != 0)
            @(negedge clk);
    endtask

    // Draw a code point, weighted towards the mapped ranges
    function automatic logic [20:0] pick_code_point();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 30)
            return 21'($urandom_range(32, 126));
        else if (r < 35)
            return 21'd10;
        else if (r < 40)
            return ($urandom_range(0, 1) != 0) ? 21'd127 : 21'($urandom_range(0, 31));
        else if (r < 60)
            return 21'($urandom_range(16'h80, 16'hFF));
        else if (r < 70)
        begin
            case ($urandom_range(0, 14))
                0:       return 21'h0000C6;
                1:       return 21'h0000DF;
                2:       return 21'h0000E6;
                3:       return 21'h000152;
                4:       return 21'h000153;
                5:       return 21'h0000A0;
                6:       return 21'h0000A1;
                7:       return 21'h0000BF;
                8:       return 21'h002013;
                9:       return 21'h002014;
                10:      return 21'h002018;
                11:      return 21'h002019;
                12:      return 21'h00201C;
                13:      return 21'h00201D;
                default: return 21'h002026;
            endcase
        end
        else if (r < 82)
            return 21'($urandom_range(16'h0100, 16'hFFFF));
        else if (r < 92)
            return 21'($urandom_range(32'h10000, 32'h10FFFF));
        return 21'($urandom_range(32'h110000, 32'h1FFFFF));
    endfunction

    // Encode a code point, sometimes overlong, truncated or with a broken continuation
    task automatic send_code_point(input logic [20:0] cp);
        logic [7:0]  seq [4];
        int unsigned n;
        int unsigned cut;
        int unsigned r;
        int unsigned i;
        logic [1:0]  top_bits;
        logic        fin_last;
        n = (cp < 21'h80) ? 1 : (cp < 21'h800) ? 2 : (cp < 21'h10000) ? 3 : 4;
        r = $urandom_range(0, 99);
        // stretch past the shortest form
        if (r >= 82 && r < 88 && n < 4)
            n = $urandom_range(n + 1, 4);
        case (n)
            1: seq[0] = {1'b0, cp[6:0]};
            2:
            begin
                seq[0] = {3'b110, cp[10:6]};
                seq[1] = {2'b10, cp[5:0]};
            end
            3:
            begin
                seq[0] = {4'b1110, cp[15:12]};
                seq[1] = {2'b10, cp[11:6]};
                seq[2] = {2'b10, cp[5:0]};
            end
            default:
            begin
                seq[0] = {5'b11110, cp[20:18]};
                seq[1] = {2'b10, cp[17:12]};
                seq[2] = {2'b10, cp[11:6]};
                seq[3] = {2'b10, cp[5:0]};
            end
        endcase
        cut      = n;
        fin_last = ($urandom_range(0, 9) == 0);
        if (r >= 88 && r < 93 && n > 1)
        begin
            // end the text in mid-sequence
            cut      = $urandom_range(1, n - 1);
            fin_last = 1'b1;
        end
        else if (r >= 93 && n > 1)
        begin
            // break one continuation byte
            top_bits = 2'($urandom_range(0, 2));
            if (top_bits == 2'd2)
                top_bits = 2'd3;
            seq[$urandom_range(1, n - 1)] = {top_bits, 6'($urandom_range(0, 63))};
        end
        for (i = 0; i < cut; i++)
            put_byte(seq[i], fin_last && (i == cut - 1));
    endtask

    initial
    begin
        int unsigned phase;
        int unsigned target;

        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed bytes: every glyph kind, then each way a sequence can fail
        send_idle_pct = 24;
        recv_idle_pct = 78;
        put_byte(8'h0A, 1'b0);
        put_byte(8'h7E, 1'b0);
        put_byte(8'h00, 1'b0);
        put_byte(8'hC3, 1'b0);
        put_byte(8'hA9, 1'b0);
        put_byte(8'hC3, 1'b0);
        put_byte(8'h86, 1'b0);
        put_byte(8'hC2, 1'b0);
        put_byte(8'hA1, 1'b0);
        put_byte(8'hE2, 1'b0);
        put_byte(8'h80, 1'b0);
        put_byte(8'h94, 1'b0);
        put_byte(8'hF0, 1'b0);
        put_byte(8'h9F, 1'b0);
        put_byte(8'h98, 1'b0);
        put_byte(8'h80, 1'b0);
        wait_for_glyphs();
        put_byte(8'h80, 1'b0);
        put_byte(8'hFF, 1'b1);
        put_byte(8'hC3, 1'b0);
        put_byte(8'h41, 1'b0);
        put_byte(8'hC0, 1'b0);
        put_byte(8'h80, 1'b0);
        put_byte(8'hE2, 1'b0);
        put_byte(8'h80, 1'b1);
        put_byte(8'hC3, 1'b1);
        wait_for_glyphs();

        // Random text in three pacing phases, draining between them
        target = bytes_sent;
        for (phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle_pct = 24;
                    recv_idle_pct = 78;
                end
                1:
                begin
                    send_idle_pct = 78;
                    recv_idle_pct = 24;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            target += 600;
            while (bytes_sent < target)
            begin
                if ($urandom_range(0, 99) < 4)
                    put_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
                else
                    send_code_point(pick_code_point());
            end
            wait_for_glyphs();
        end

        // allow for anything the block might still emit
        repeat (8) @(negedge clk);
        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // Watchdog
    initial
    begin
        #2_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule
